// File: rtl/mavc_pkg.sv
// ----------------------------------------------------------------------------
// mavc_pkg
// Shared constants, word types and table functions for the flow state to
// velocity component pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package mavc_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FRACTION_BITS_DEF = 16;

    // angle in Q.40 radians, signed
    localparam int ZW     = 44;
    localparam int SPEED_W = 37;
    localparam int ROOT_W = 32;
    localparam int RAD_W  = 64;
    localparam int REM_W  = 34;

    localparam longint unsigned PI_Q32    = 64'd13493037705;
    localparam longint unsigned K_INF_Q32 = 64'd2608131496;

    localparam logic signed [25:0] QUARTER_DEG = 26'sd5898240;
    localparam logic signed [25:0] HALF_DEG    = 26'sd11796480;

    // pi_q32 / 46080 split into quotient and remainder
    localparam logic [18:0] PI_QUOT = 19'd292817;
    localparam logic [14:0] PI_REM  = 15'd30345;
    // ceil(2^34 / 45), exact for dividends below 2^28
    localparam logic [28:0] RECIP45 = 29'd381774871;
    localparam int RECIP_SHIFT = 34;

    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

    // configuration register indexes
    localparam logic REG_GAMMA = 1'b0;
    localparam logic REG_GASR  = 1'b1;

    typedef struct packed {
        logic [23:0]          mach;
        logic signed [ZW-1:0] z;
        logic                 flip;
        logic [31:0]          pres;
        logic [31:0]          temp;
    } root_side_t;

    typedef struct packed {
        logic        flip;
        logic [31:0] pres;
        logic [31:0] temp;
    } rot_side_t;

    // restoring long division for the series terms
    function automatic longint unsigned series_div(input longint unsigned num,
                                                   input int den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= 64'(den))
            begin
                rem    = rem - 64'(den);
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // arctan(2^-i) in Q.40 radians from the odd power series in Q.62
    function automatic longint unsigned atan_q40(input int i);
        longint unsigned sum;
        longint unsigned term;
        int              k;
        bit              minus;
        sum   = 64'd0;
        minus = 1'b0;
        if (i == 0)
            return PI_Q32 * 64;
        for (k = 1; i * k <= 62; k += 2)
        begin
            term = series_div(64'd1 << (62 - i * k), k);
            sum  = minus ? sum - term : sum + term;
            minus = !minus;
        end
        return (sum + (64'd1 << 21)) >> 22;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mavc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// mavc_sqrt_cell
// One digit step of the restoring square root: two radicand bits in, one
// root bit out, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mavc_sqrt_cell (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    input  wire  [mavc_pkg::REM_W-1:0]            in_rem,
    input  wire  [mavc_pkg::ROOT_W-1:0]           in_root,
    input  wire  [mavc_pkg::RAD_W-1:0]            in_rad,
    input  mavc_pkg::root_side_t                  in_side,
    output logic                                  out_valid,
    output logic [mavc_pkg::REM_W-1:0]            out_rem,
    output logic [mavc_pkg::ROOT_W-1:0]           out_root,
    output logic [mavc_pkg::RAD_W-1:0]            out_rad,
    output mavc_pkg::root_side_t                  out_side
);
    import mavc_pkg::*;

    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              ge;
    logic              valid_reg;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [RAD_W-1:0]  rad_reg;
    root_side_t        side_reg;

    always_comb
    begin
        cur       = {in_rem, in_rad[RAD_W-1 -: 2]};
        trial     = {2'b00, in_root, 2'b01};
        diff      = cur - trial;
        ge        = (cur >= trial);
        rem_next  = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
        root_next = {in_root[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        rad_reg  <= {in_rad[RAD_W-3:0], 2'b00};
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_rad   = rad_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// File: rtl/mavc_cordic_cell.sv
// ----------------------------------------------------------------------------
// mavc_cordic_cell
// One rotation step of the rotation-mode CORDIC, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mavc_cordic_cell #(
    parameter int STAGE = 0,
    parameter int XW    = 56
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    input  wire  signed [XW-1:0]              in_x,
    input  wire  signed [XW-1:0]              in_y,
    input  wire  signed [mavc_pkg::ZW-1:0]    in_z,
    input  mavc_pkg::rot_side_t               in_side,
    output logic                              out_valid,
    output logic signed [XW-1:0]              out_x,
    output logic signed [XW-1:0]              out_y,
    output logic signed [mavc_pkg::ZW-1:0]    out_z,
    output mavc_pkg::rot_side_t               out_side
);
    import mavc_pkg::*;

    localparam longint unsigned ATAN_FULL = atan_q40(STAGE);
    localparam logic signed [ZW-1:0] ATAN = ATAN_FULL[ZW-1:0];

    logic signed [XW-1:0] dx, dy;
    logic signed [XW-1:0] x_next, y_next;
    logic signed [ZW-1:0] z_next;
    logic                 valid_reg;
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    rot_side_t            side_reg;

    always_comb
    begin
        dx = in_y >>> STAGE;
        dy = in_x >>> STAGE;
        if (!in_z[ZW-1])
        begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - ATAN;
        end
        else
        begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// File: rtl/mach_angle_to_velocity_components_core.sv
// ----------------------------------------------------------------------------
// mach_angle_to_velocity_components_core
// Flow state to velocity components: sound speed by square root, speed by
// Mach times sound speed, rotation by the flow angle in a CORDIC chain.
// ----------------------------------------------------------------------------
// Usage:
//   A word (mach, angle, pressure, temperature) is taken at a rising edge with
//   start high and busy low. busy stays low, so a new word can come in every
//   cycle.
//   The result (pressure, velocity x/y, temperature) shows for one cycle with
//   done high, after the word has passed five front stages, the 32 square root
//   digit cells, two speed stages, one cell per CORDIC stage and the output
//   register. Throughput is one word per cycle.
//   Results leave in the order the words came in; the receiver cannot stall.
//   gamma and R are to be written via cfg_write/cfg_index/cfg_data only with
//   the pipeline empty (not enforced); the product is registered next cycle.
//   Reset clears all valid flags and loads gamma = 1.4 and R = 287.046.
// ----------------------------------------------------------------------------
`default_nettype none

module mach_angle_to_velocity_components_core #(
    parameter int CORDIC_STAGES = mavc_pkg::CORDIC_STAGES_DEF,
    parameter int FRACTION_BITS = mavc_pkg::FRACTION_BITS_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_write,
    input  wire                cfg_index,
    input  wire  [31:0]        cfg_data,
    input  wire                start,
    output logic               busy,
    input  wire  [23:0]        mach_number,
    input  wire  signed [24:0] flow_angle_deg,
    input  wire  [31:0]        pressure_in,
    input  wire  [31:0]        temperature_in,
    output logic               done,
    output logic [31:0]        pressure_out,
    output logic signed [31:0] velocity_x,
    output logic signed [31:0] velocity_y,
    output logic [31:0]        temperature_out
);
    import mavc_pkg::*;

    localparam int XW = FRACTION_BITS + 40;
    localparam int LATENCY = 39 + CORDIC_STAGES;
    localparam longint unsigned K32 =
        K_INF_Q32 + (64'd2 * K_INF_Q32) / (64'd3 << (2 * CORDIC_STAGES));
    localparam longint unsigned GAIN_FULL =
        (K32 + (64'd1 << (31 - FRACTION_BITS))) >> (32 - FRACTION_BITS);
    localparam logic [FRACTION_BITS-1:0] GAIN = GAIN_FULL[FRACTION_BITS-1:0];

    // configuration
    logic [17:0] gamma_reg;
    logic [31:0] gasr_reg;
    logic [33:0] gr_reg;
    logic [49:0] gr_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= 18'd91750;
            gasr_reg  <= 32'd18811847;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GAMMA: gamma_reg <= cfg_data[17:0];
                REG_GASR:  gasr_reg  <= cfg_data;
                default:   gasr_reg  <= gasr_reg;
            endcase
        end
    end

    assign gr_prod = gamma_reg * gasr_reg;

    always_ff @(posedge clk)
    begin
        gr_reg <= gr_prod[49:16];
    end

    assign busy = 1'b0;

    // front stages
    logic              f0_valid_reg, f1_valid_reg, f2_valid_reg, f3_valid_reg, f4_valid_reg;
    logic [23:0]       f0_mach_reg;
    logic signed [24:0] f0_angle_reg;
    logic [31:0]       f0_pres_reg, f0_temp_reg;

    logic signed [25:0] zdeg, zred;
    logic              flip_next, neg_next;
    logic [22:0]       mag_next;

    logic [48:0]       f1_plo_reg, f1_phi_reg;
    logic [22:0]       f1_mag_reg;
    logic              f1_neg_reg, f1_flip_reg;
    logic [23:0]       f1_mach_reg;
    logic [31:0]       f1_pres_reg, f1_temp_reg;

    logic [66:0]       a2_sum;
    logic [63:0]       f2_a2_reg;
    logic [41:0]       f2_p1_reg;
    logic [37:0]       f2_p2_reg;
    logic              f2_neg_reg, f2_flip_reg;
    logic [23:0]       f2_mach_reg;
    logic [31:0]       f2_pres_reg, f2_temp_reg;

    logic [27:0]       f3_t;
    logic [63:0]       f3_a2_reg;
    logic [41:0]       f3_p1_reg;
    logic [56:0]       f3_q_reg;
    logic              f3_neg_reg, f3_flip_reg;
    logic [23:0]       f3_mach_reg;
    logic [31:0]       f3_pres_reg, f3_temp_reg;

    logic [ZW-1:0]     zmag;
    logic [63:0]       f4_a2_reg;
    root_side_t        f4_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
            f4_valid_reg <= 1'b0;
        end
        else
        begin
            f0_valid_reg <= start && !busy;
            f1_valid_reg <= f0_valid_reg;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
            f4_valid_reg <= f3_valid_reg;
        end
    end

    // fold the angle into [-90, 90]; the half turn flips the final vector
    always_comb
    begin
        zdeg      = {f0_angle_reg[24], f0_angle_reg};
        zred      = zdeg;
        flip_next = 1'b0;
        if (zdeg > QUARTER_DEG)
        begin
            zred      = zdeg - HALF_DEG;
            flip_next = 1'b1;
        end
        else if (zdeg < -QUARTER_DEG)
        begin
            zred      = zdeg + HALF_DEG;
            flip_next = 1'b1;
        end
        neg_next = zred[25];
        mag_next = neg_next ? 23'(-zred) : zred[22:0];
    end

    assign a2_sum = {18'd0, f1_plo_reg} + {1'b0, f1_phi_reg, 17'd0};
    assign f3_t   = f2_p2_reg[37:10];
    assign zmag   = ZW'(f3_p1_reg) + ZW'(f3_q_reg[56:RECIP_SHIFT]);

    always_ff @(posedge clk)
    begin
        f0_mach_reg  <= mach_number;
        f0_angle_reg <= flow_angle_deg;
        f0_pres_reg  <= pressure_in;
        f0_temp_reg  <= temperature_in;

        f1_plo_reg  <= gr_reg[16:0] * f0_temp_reg;
        f1_phi_reg  <= gr_reg[33:17] * f0_temp_reg;
        f1_mag_reg  <= mag_next;
        f1_neg_reg  <= neg_next;
        f1_flip_reg <= flip_next;
        f1_mach_reg <= f0_mach_reg;
        f1_pres_reg <= f0_pres_reg;
        f1_temp_reg <= f0_temp_reg;

        f2_a2_reg   <= (a2_sum[66:64] != 3'd0) ? {64{1'b1}} : a2_sum[63:0];
        f2_p1_reg   <= f1_mag_reg * PI_QUOT;
        f2_p2_reg   <= f1_mag_reg * PI_REM;
        f2_neg_reg  <= f1_neg_reg;
        f2_flip_reg <= f1_flip_reg;
        f2_mach_reg <= f1_mach_reg;
        f2_pres_reg <= f1_pres_reg;
        f2_temp_reg <= f1_temp_reg;

        f3_a2_reg   <= f2_a2_reg;
        f3_p1_reg   <= f2_p1_reg;
        f3_q_reg    <= f3_t * RECIP45;
        f3_neg_reg  <= f2_neg_reg;
        f3_flip_reg <= f2_flip_reg;
        f3_mach_reg <= f2_mach_reg;
        f3_pres_reg <= f2_pres_reg;
        f3_temp_reg <= f2_temp_reg;

        f4_a2_reg        <= f3_a2_reg;
        f4_side_reg.mach <= f3_mach_reg;
        f4_side_reg.z    <= f3_neg_reg ? -signed'(zmag) : signed'(zmag);
        f4_side_reg.flip <= f3_flip_reg;
        f4_side_reg.pres <= f3_pres_reg;
        f4_side_reg.temp <= f3_temp_reg;
    end

    // square root chain
    logic              sq_valid [ROOT_W+1];
    logic [REM_W-1:0]  sq_rem   [ROOT_W+1];
    logic [ROOT_W-1:0] sq_root  [ROOT_W+1];
    logic [RAD_W-1:0]  sq_rad   [ROOT_W+1];
    root_side_t        sq_side  [ROOT_W+1];

    assign sq_valid[0] = f4_valid_reg;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_rad[0]   = f4_a2_reg;
    assign sq_side[0]  = f4_side_reg;

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_sqrt
        mavc_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[g]),
            .in_rem    (sq_rem[g]),
            .in_root   (sq_root[g]),
            .in_rad    (sq_rad[g]),
            .in_side   (sq_side[g]),
            .out_valid (sq_valid[g+1]),
            .out_rem   (sq_rem[g+1]),
            .out_root  (sq_root[g+1]),
            .out_rad   (sq_rad[g+1]),
            .out_side  (sq_side[g+1])
        );
    end

    // speed and initial vector
    logic               s1_valid_reg, s2_valid_reg;
    logic [55:0]        s1_prod_reg;
    root_side_t         s1_side_reg;
    logic [SPEED_W-1:0] spd;
    logic [SPEED_W+FRACTION_BITS-1:0] x0_prod;
    logic signed [XW-1:0] s2_x_reg;
    logic signed [ZW-1:0] s2_z_reg;
    rot_side_t          s2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= sq_valid[ROOT_W];
            s2_valid_reg <= s1_valid_reg;
        end
    end

    assign spd     = (s1_prod_reg[55:16] > 40'(SPEED_MAX)) ? SPEED_MAX
                                                           : s1_prod_reg[16+SPEED_W-1:16];
    assign x0_prod = spd * GAIN;

    always_ff @(posedge clk)
    begin
        s1_prod_reg      <= sq_side[ROOT_W].mach * sq_root[ROOT_W];
        s1_side_reg      <= sq_side[ROOT_W];
        s2_x_reg         <= signed'(XW'(x0_prod));
        s2_z_reg         <= s1_side_reg.z;
        s2_side_reg.flip <= s1_side_reg.flip;
        s2_side_reg.pres <= s1_side_reg.pres;
        s2_side_reg.temp <= s1_side_reg.temp;
    end

    // rotation chain
    logic                 cr_valid [CORDIC_STAGES+1];
    logic signed [XW-1:0] cr_x     [CORDIC_STAGES+1];
    logic signed [XW-1:0] cr_y     [CORDIC_STAGES+1];
    logic signed [ZW-1:0] cr_z     [CORDIC_STAGES+1];
    rot_side_t            cr_side  [CORDIC_STAGES+1];

    assign cr_valid[0] = s2_valid_reg;
    assign cr_x[0]     = s2_x_reg;
    assign cr_y[0]     = '0;
    assign cr_z[0]     = s2_z_reg;
    assign cr_side[0]  = s2_side_reg;

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cordic
        mavc_cordic_cell #(
            .STAGE (g),
            .XW    (XW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cr_valid[g]),
            .in_x      (cr_x[g]),
            .in_y      (cr_y[g]),
            .in_z      (cr_z[g]),
            .in_side   (cr_side[g]),
            .out_valid (cr_valid[g+1]),
            .out_x     (cr_x[g+1]),
            .out_y     (cr_y[g+1]),
            .out_z     (cr_z[g+1]),
            .out_side  (cr_side[g+1])
        );
    end

    // flip, round and clamp
    localparam logic signed [XW-1:0] HALF_LSB = XW'(1) <<< (FRACTION_BITS - 1);
    localparam logic signed [XW-1:0] OUT_MAX = {{(XW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [XW-1:0] OUT_MIN = {{(XW-31){1'b1}}, {31{1'b0}}};

    logic signed [XW-1:0] wx, wy, rx, ry;
    logic [31:0]          vx_next, vy_next;
    logic                 done_reg;
    logic [31:0]          pres_reg, temp_reg, vx_reg, vy_reg;

    always_comb
    begin
        wx = cr_side[CORDIC_STAGES].flip ? -cr_x[CORDIC_STAGES] : cr_x[CORDIC_STAGES];
        wy = cr_side[CORDIC_STAGES].flip ? -cr_y[CORDIC_STAGES] : cr_y[CORDIC_STAGES];
        rx = (wx + HALF_LSB) >>> FRACTION_BITS;
        ry = (wy + HALF_LSB) >>> FRACTION_BITS;
        if (rx > OUT_MAX)
            vx_next = 32'h7fff_ffff;
        else if (rx < OUT_MIN)
            vx_next = 32'h8000_0000;
        else
            vx_next = rx[31:0];
        if (ry > OUT_MAX)
            vy_next = 32'h7fff_ffff;
        else if (ry < OUT_MIN)
            vy_next = 32'h8000_0000;
        else
            vy_next = ry[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cr_valid[CORDIC_STAGES];
    end

    always_ff @(posedge clk)
    begin
        pres_reg <= cr_side[CORDIC_STAGES].pres;
        temp_reg <= cr_side[CORDIC_STAGES].temp;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
    end

    assign done            = done_reg;
    assign pressure_out    = pres_reg;
    assign temperature_out = temp_reg;
    assign velocity_x      = signed'(vx_reg);
    assign velocity_y      = signed'(vy_reg);

    // every accepted word comes out after the full pipeline depth
    assert property (@(posedge clk) disable iff (!rst_n)
        f0_valid_reg |-> ##LATENCY done)
        else $error("accepted word did not reach the output");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && cfg_index == REG_GAMMA) |=> gamma_reg == $past(cfg_data[17:0]))
        else $error("gamma write lost");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && cfg_index == REG_GASR) |=> gasr_reg == $past(cfg_data))
        else $error("gas constant write lost");

    // square root cell output never exceeds twice the root
    assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid[ROOT_W] |-> ({2'b00, sq_rem[ROOT_W]} <= {3'b000, sq_root[ROOT_W], 1'b0}))
        else $error("square root remainder out of range");

endmodule

`default_nettype wire

// File: verif/mavc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavc_checker
// Watches the config, input and result ports of the velocity core, computes
// the expected velocity words in software fixed point and compares them in
// order against the words the core hands out.
// ----------------------------------------------------------------------------
module mavc_checker (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_write,
    input  wire                cfg_index,
    input  wire  [31:0]        cfg_data,
    input  wire                start,
    input  wire                busy,
    input  wire  [23:0]        mach_number,
    input  wire  signed [24:0] flow_angle_deg,
    input  wire  [31:0]        pressure_in,
    input  wire  [31:0]        temperature_in,
    input  wire                done,
    input  wire  [31:0]        pressure_out,
    input  wire  signed [31:0] velocity_x,
    input  wire  signed [31:0] velocity_y,
    input  wire  [31:0]        temperature_out,
    output int                 fail_count,
    output int                 pending
);
    import mavc_pkg::*;

    localparam int STAGES = CORDIC_STAGES_DEF;
    localparam int FB     = FRACTION_BITS_DEF;

    typedef struct packed {
        logic [31:0]        pres;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [31:0]        temp;
    } flow_word_t;

    flow_word_t vel_queue[$];
    logic [17:0] gamma_q;
    logic [31:0] gas_r_q;
    longint atan_tab[STAGES];

    function automatic longint floor_sh(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint atan_entry(input int i);
        longint unsigned sum;
        longint unsigned term;
        int              k;
        bit              neg;
        sum = 0;
        neg = 0;
        if (i == 0)
            return 64'd13493037705 * 64;
        for (k = 1; i * k <= 62; k += 2)
        begin
            term = (64'd1 << (62 - i * k)) / k;
            sum  = neg ? sum - term : sum + term;
            neg  = !neg;
        end
        return longint'((sum + (64'd1 << 21)) >> 22);
    endfunction

    function automatic longint unsigned isqrt64(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] round_sat(input longint v);
        longint r;
        r = floor_sh(v + (longint'(1) << (FB - 1)), FB);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic flow_word_t predict_velocity(input logic [23:0] mach,
                                                    input logic signed [24:0] ang,
                                                    input logic [31:0] pres,
                                                    input logic [31:0] temp);
        flow_word_t      w;
        longint unsigned gr, a2, a, spd, k32, gain;
        longint          x, y, z, zdeg, dx, dy;
        bit              flip;
        int              i;
        flip = 0;
        gr = (64'(gamma_q) * 64'(gas_r_q)) >> 16;
        if (temp != 0 && gr > 64'hFFFF_FFFF_FFFF_FFFF / temp)
            a2 = 64'hFFFF_FFFF_FFFF_FFFF;
        else
            a2 = gr * temp;
        a = isqrt64(a2);
        spd = (64'(mach) * a) >> 16;
        if (spd > 64'd137438953471)
            spd = 64'd137438953471;
        zdeg = longint'(ang);
        if (zdeg > 90 * 65536)
        begin
            zdeg -= 180 * 65536;
            flip = 1;
        end
        else if (zdeg < -90 * 65536)
        begin
            zdeg += 180 * 65536;
            flip = 1;
        end
        z = (zdeg * 64'sd13493037705) / 46080;
        k32 = 64'd2608131496 + (2 * 64'd2608131496) / (64'd3 << (2 * STAGES));
        gain = (k32 + (64'd1 << (31 - FB))) >> (32 - FB);
        x = longint'(spd) * longint'(gain);
        y = 0;
        for (i = 0; i < STAGES; i++)
        begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_tab[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_tab[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        w.pres = pres;
        w.vx   = round_sat(x);
        w.vy   = round_sat(y);
        w.temp = temp;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial
    begin
        for (int i = 0; i < STAGES; i++)
            atan_tab[i] = atan_entry(i);
    end

    assign pending = vel_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        flow_word_t w;
        if (!rst_n)
        begin
            gamma_q    <= 18'd91750;
            gas_r_q    <= 32'd18811847;
            fail_count = 0;
            vel_queue.delete();
        end
        else
        begin
            if (done)
            begin
                if (vel_queue.size() == 0)
                    report_mismatch("unexpected word", pressure_out, 32'h0);
                else
                begin
                    w = vel_queue.pop_front();
                    if (pressure_out !== w.pres)
                        report_mismatch("pressure_out", pressure_out, w.pres);
                    if (velocity_x !== w.vx)
                        report_mismatch("velocity_x", velocity_x, w.vx);
                    if (velocity_y !== w.vy)
                        report_mismatch("velocity_y", velocity_y, w.vy);
                    if (temperature_out !== w.temp)
                        report_mismatch("temperature_out", temperature_out, w.temp);
                end
            end
            if (start && !busy)
                vel_queue.push_back(predict_velocity(mach_number, flow_angle_deg,
                                                     pressure_in, temperature_in));
            if (cfg_write)
            begin
                if (cfg_index == REG_GAMMA)
                    gamma_q <= cfg_data[17:0];
                else if (cfg_index == REG_GASR)
                    gas_r_q <= cfg_data;
            end
        end
    end
endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams flow state words through the velocity core under several gamma and
// gas constant settings, random start gaps or none; checker scores results.
// ----------------------------------------------------------------------------
module tb;
    import mavc_pkg::*;

    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 200000;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               cfg_write = 0;
    logic               cfg_index = REG_GAMMA;
    logic [31:0]        cfg_data = 0;
    logic               start = 0;
    logic [23:0]        mach_number = 0;
    logic signed [24:0] flow_angle_deg = 0;
    logic [31:0]        pressure_in = 0;
    logic [31:0]        temperature_in = 0;
    wire                busy, done;
    wire  [31:0]        pressure_out, temperature_out;
    wire  signed [31:0] velocity_x, velocity_y;
    int                 fail_count, pending;
    int                 cycles = 0;
    bit                 no_gaps = 0;

    always #10 clk = ~clk;

    mach_angle_to_velocity_components_core u_top (.*);

    mavc_checker u_chk (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 0;
        @(posedge clk);
    endtask

    // one word; leaves start high, so back-to-back words run without a gap
    task automatic send_state(input logic [23:0] m, input logic signed [24:0] ang,
                              input logic [31:0] p, input logic [31:0] t);
        while (!no_gaps && $urandom_range(99) < 11)
        begin
            start <= 0;
            @(posedge clk);
        end
        start          <= 1;
        mach_number    <= m;
        flow_angle_deg <= ang;
        pressure_in    <= p;
        temperature_in <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain;
        start <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [24:0] rand_angle;
        case ($urandom_range(3))
            0: return $signed(25'($urandom));
            1: return 25'($signed($urandom_range(23592960)) - 11796480);
            default: return 25'($signed($urandom_range(11796480)) - 5898240);
        endcase
    endfunction

    function automatic logic [31:0] rand_temp;
        if ($urandom_range(3) == 0)
            return $urandom;
        return $urandom_range(32'h0200_0000, 32'h0010_0000);
    endfunction

    task automatic random_block(input int count);
        for (int i = 0; i < count; i++)
            send_state($urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(65536 * 8)),
                       rand_angle(), $urandom, rand_temp());
    endtask

    initial
    begin
        logic signed [24:0] angles[10];
        angles = '{25'sd0, 25'sd5898240, -25'sd5898240, 25'sd5898241, -25'sd5898241,
                   25'sd11796480, -25'sd11796480, 25'sd16777215, 25'sh100_0000,
                   25'sd2949120};
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset registers, field extremes, angle reductions
        foreach (angles[i])
            send_state(24'd65536 * 2, angles[i], $urandom, 32'd300 << 16);
        send_state(24'hFFFFFF, 25'sd0, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_state(24'hFFFFFF, 25'sd2949120, 32'h0, 32'hFFFFFFFF);
        send_state(24'd0, 25'sd100, 32'h0, 32'd0);
        send_state(24'd1, -25'sd1, 32'h1, 32'd1);
        drain();
        write_reg(REG_GAMMA, 32'h3FFFF);
        write_reg(REG_GASR, 32'hFFFFFFFF);
        // sound speed and speed saturation
        send_state(24'hFFFFFF, 25'sd0, 32'h5, 32'hFFFFFFFF);
        send_state(24'hFFFFFF, -25'sd11796480, 32'h6, 32'hFFFFFFFF);
        send_state(24'h010000, 25'sd1000000, 32'h7, 32'h00010000);
        drain();
        write_reg(REG_GAMMA, 32'd0);
        write_reg(REG_GASR, 32'd0);
        send_state(24'hFFFFFF, 25'sd1234567, 32'h8, 32'hFFFFFFFF);
        drain();

        write_reg(REG_GAMMA, 32'd91750);
        write_reg(REG_GASR, 32'd18811847);
        random_block(700);
        no_gaps = 1;
        random_block(300);
        no_gaps = 0;
        drain();
        write_reg(REG_GAMMA, $urandom);
        write_reg(REG_GASR, $urandom);
        random_block(500);
        drain();
        write_reg(REG_GAMMA, 32'h3FFFF);
        write_reg(REG_GASR, 32'hFFFFFFFF);
        random_block(250);
        drain();
        write_reg(REG_GAMMA, 32'd1);
        write_reg(REG_GASR, 32'd1);
        random_block(250);
        drain();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// File: files.f
rtl/mavc_pkg.sv
rtl/mavc_sqrt_cell.sv
rtl/mavc_cordic_cell.sv
rtl/mach_angle_to_velocity_components_core.sv
verif/mavc_checker.sv
verif/tb.sv
